// ----- hw/rtl/bae_pkg.sv -----
package bae_pkg;

	localparam int ATOM_BITS = 8;

	typedef logic [ATOM_BITS-1:0] atom_t;

	localparam logic OP_CLEAR = 1'b0;
	localparam logic OP_ADD   = 1'b1;

	typedef struct packed {
		logic  op;
		atom_t first_atom;
		atom_t second_atom;
	} bae_cmd_t;

	typedef struct packed {
		atom_t end_first;
		atom_t center;
		atom_t end_second;
		logic  angle_valid;
		logic  store_full;
		logic  last;
	} bae_result_t;

	typedef struct packed {
		atom_t first;
		atom_t second;
	} bae_bond_t;

	typedef struct packed {
		logic  hit;
		atom_t end_first;
		atom_t center;
		atom_t end_second;
	} bae_angle_t;

endpackage

// ----- hw/rtl/bae_bond_store.sv -----
module bae_bond_store import bae_pkg::*; #(
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  bae_bond_t                wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output bae_bond_t                rdata
);

	bae_bond_t mem [DEPTH];
	bae_bond_t rd_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	assign rdata = rd_q;

endmodule

// ----- hw/rtl/bae_match.sv -----
module bae_match import bae_pkg::*; (
	input  bae_bond_t  stored,
	input  bae_bond_t  fresh,
	output bae_angle_t angle
);

	atom_t p, q, r, s;

	assign p = stored.first;
	assign q = stored.second;
	assign r = fresh.first;
	assign s = fresh.second;

	// rules are tried in priority order, a matching rule with equal far ends gives nothing
	always_comb begin
		angle = '0;
		if (p == r) begin
			if (q != s) begin
				angle = '{hit: 1'b1, end_first: q, center: p, end_second: s};
			end
		end else if (p == s) begin
			if (q != r) begin
				angle = '{hit: 1'b1, end_first: q, center: p, end_second: r};
			end
		end else if (q == r) begin
			if (p != s) begin
				angle = '{hit: 1'b1, end_first: p, center: q, end_second: s};
			end
		end else if (q == s) begin
			if (p != r) begin
				angle = '{hit: 1'b1, end_first: p, center: q, end_second: r};
			end
		end
	end

endmodule

// ----- hw/rtl/bond_angle_enumerator.sv -----
// channel   ports                   handshake
// command   cmd (bae_cmd_t)         taken at clk edge with start high and busy low
// result    result (bae_result_t)   one word per cycle where strobe is high, no backpressure
//
// clear, add into a full table and add into an empty table: busy stays low, one word
// appears the cycle after acceptance. add with n stored bonds: busy after acceptance through
// the scan, tail and finish states, with one compare per cycle against the bond table
// read port. a result word is held in pend_q until a later hit or the finish state, then registered.
// arst_n empties the table (count only); table contents need no clearing.
module bond_angle_enumerator import bae_pkg::*; #(
	parameter int MAX_BONDS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  bae_cmd_t    cmd,
	output logic        strobe,
	output bae_result_t result
);

	localparam int IDX_W = $clog2(MAX_BONDS);
	localparam int CNT_W = $clog2(MAX_BONDS + 1);

	typedef enum logic [3:0] {
		S_IDLE   = 4'b0001,
		S_SCAN   = 4'b0010,
		S_TAIL   = 4'b0100,
		S_FINISH = 4'b1000
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   count_q;
	logic [IDX_W-1:0]   idx_q;
	logic [IDX_W-1:0]   last_idx_q;
	bae_bond_t          new_q;
	bae_angle_t         pend_q;
	logic               rd_vld_s1;
	logic               rd_last_s1;
	logic               strobe_q;
	bae_result_t        result_q;

	logic               accept;
	logic               full;
	logic               we;
	bae_bond_t          wdata;
	bae_bond_t          rdata;
	bae_angle_t         angle;

	assign accept = start && (state_q == S_IDLE);
	assign full   = count_q >= CNT_W'(MAX_BONDS);
	assign we     = accept && (cmd.op == OP_ADD) && !full;
	assign wdata  = '{first: cmd.first_atom, second: cmd.second_atom};

	bae_bond_store #(.DEPTH(MAX_BONDS)) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (wdata),
		.raddr (idx_q),
		.rdata (rdata)
	);

	bae_match u_match (
		.stored (rdata),
		.fresh  (new_q),
		.angle  (angle)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			count_q    <= '0;
			pend_q     <= '0;
			rd_vld_s1  <= 1'b0;
			rd_last_s1 <= 1'b0;
			strobe_q   <= 1'b0;
			result_q   <= '0;
			new_q      <= '0;
			idx_q      <= '0;
			last_idx_q <= '0;
		end else begin
			strobe_q  <= 1'b0;
			rd_vld_s1 <= 1'b0;

			// one hit is held back so the final one can carry last
			if (rd_vld_s1 && angle.hit) begin
				if (pend_q.hit) begin
					strobe_q <= 1'b1;
					result_q <= '{end_first: pend_q.end_first, center: pend_q.center,
						end_second: pend_q.end_second, angle_valid: 1'b1,
						store_full: 1'b0, last: 1'b0};
				end
				pend_q <= angle;
			end

			unique case (state_q)
				S_IDLE: begin
					if (start) begin
						if (cmd.op == OP_CLEAR) begin
							count_q  <= '0;
							strobe_q <= 1'b1;
							result_q <= '{default: '0, last: 1'b1};
						end else if (full) begin
							strobe_q <= 1'b1;
							result_q <= '{default: '0, store_full: 1'b1, last: 1'b1};
						end else begin
							count_q <= count_q + CNT_W'(1);
							new_q   <= wdata;
							if (count_q == '0) begin
								strobe_q <= 1'b1;
								result_q <= '{default: '0, last: 1'b1};
							end else begin
								idx_q      <= '0;
								last_idx_q <= IDX_W'(count_q - CNT_W'(1));
								pend_q     <= '0;
								state_q    <= S_SCAN;
							end
						end
					end
				end
				S_SCAN: begin
					rd_vld_s1  <= 1'b1;
					rd_last_s1 <= (idx_q == last_idx_q);
					idx_q      <= idx_q + IDX_W'(1);
					if (idx_q == last_idx_q) begin
						state_q <= S_TAIL;
					end
				end
				S_TAIL: begin
					// compare of the newest stored bond happens here
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					strobe_q <= 1'b1;
					if (pend_q.hit) begin
						result_q <= '{end_first: pend_q.end_first, center: pend_q.center,
							end_second: pend_q.end_second, angle_valid: 1'b1,
							store_full: 1'b0, last: 1'b1};
					end else begin
						result_q <= '{default: '0, last: 1'b1};
					end
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign busy   = (state_q != S_IDLE);
	assign strobe = strobe_q;
	assign result = result_q;

	a_more_follows: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("non-final word while sequencer idle");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.angle_valid |-> result.last)
		else $error("status word without last");

	a_angle_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result.angle_valid |-> !result.store_full)
		else $error("angle word flagged full");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_BONDS))
		else $error("bond count beyond table depth");

	a_tail_compares: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_TAIL |-> rd_vld_s1 && rd_last_s1)
		else $error("tail state without final compare");

endmodule

// ----- test/testbench.sv -----
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import bae_pkg::*;

	localparam int TABLE_DEPTH = 64;
	localparam int WORD_TARGET = 430;
	localparam int QUIET_LIMIT = 5000;

	// tracks the bond table and the angle words each command should produce
	class angle_checker;
		bae_bond_t bonds[TABLE_DEPTH];
		int bond_total;
		bae_result_t pending[$];
		int faults;
		int commands;
		int clears;
		int drops;
		int angle_words;
		int status_words;

		function new();
			bond_total = 0;
			faults = 0;
			commands = 0;
			clears = 0;
			drops = 0;
			angle_words = 0;
			status_words = 0;
		endfunction

		function int pending_size();
			return pending.size();
		endfunction

		function void expect_word(bae_result_t w);
			pending.insert(pending.size(), w);
		endfunction

		function string describe(bae_result_t w);
			return $sformatf("ends %0d/%0d center %0d valid %0b full %0b last %0b",
				w.end_first, w.end_second, w.center, w.angle_valid, w.store_full, w.last);
		endfunction

		function void note_command(bae_cmd_t c);
			bae_result_t w;
			bae_bond_t b;
			int found;
			logic hit;
			atom_t outer_a;
			atom_t mid;
			atom_t outer_b;
			commands++;
			w = '0;
			if (c.op == OP_CLEAR) begin
				bond_total = 0;
				clears++;
				w.last = 1'b1;
				expect_word(w);
				return;
			end
			if (bond_total >= TABLE_DEPTH) begin
				drops++;
				w.store_full = 1'b1;
				w.last = 1'b1;
				expect_word(w);
				return;
			end
			found = 0;
			for (int i = 0; i < bond_total; i++) begin
				b = bonds[i];
				hit = 1'b1;
				outer_a = '0;
				mid = '0;
				outer_b = '0;
				// the first shared atom decides, even when that pairing is degenerate
				if (b.first == c.first_atom) begin
					hit = (b.second != c.second_atom);
					outer_a = b.second;
					mid = b.first;
					outer_b = c.second_atom;
				end else if (b.first == c.second_atom) begin
					hit = (b.second != c.first_atom);
					outer_a = b.second;
					mid = b.first;
					outer_b = c.first_atom;
				end else if (b.second == c.first_atom) begin
					hit = (b.first != c.second_atom);
					outer_a = b.first;
					mid = b.second;
					outer_b = c.second_atom;
				end else if (b.second == c.second_atom) begin
					hit = (b.first != c.first_atom);
					outer_a = b.first;
					mid = b.second;
					outer_b = c.first_atom;
				end else begin
					hit = 1'b0;
				end
				if (hit) begin
					w = '0;
					w.end_first = outer_a;
					w.center = mid;
					w.end_second = outer_b;
					w.angle_valid = 1'b1;
					expect_word(w);
					found++;
				end
			end
			b.first = c.first_atom;
			b.second = c.second_atom;
			bonds[bond_total] = b;
			bond_total++;
			if (found == 0) begin
				w = '0;
				w.last = 1'b1;
				expect_word(w);
			end else begin
				w = pending[pending.size() - 1];
				w.last = 1'b1;
				pending[pending.size() - 1] = w;
			end
		endfunction

		function void check_word(bae_result_t got);
			bae_result_t want;
			if (pending.size() == 0) begin
				faults++;
				if (faults <= 10)
					$display("unexpected word at %0t: %s", $time, describe(got));
				return;
			end
			want = pending.pop_front();
			if (want.angle_valid)
				angle_words++;
			else
				status_words++;
			if (got.end_first !== want.end_first || got.center !== want.center ||
					got.end_second !== want.end_second ||
					got.angle_valid !== want.angle_valid ||
					got.store_full !== want.store_full || got.last !== want.last) begin
				faults++;
				if (faults <= 10)
					$display("word mismatch at %0t: expected %s, got %s",
						$time, describe(want), describe(got));
			end
		endfunction
	endclass

	logic clk;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	bae_cmd_t cmd = '0;
	logic busy;
	logic strobe;
	bae_result_t result;

	angle_checker board = new();
	int sent = 0;
	int idle_pct = 0;
	int quiet = 0;

	bond_angle_enumerator #(.MAX_BONDS(TABLE_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.strobe(strobe),
		.result(result)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (strobe)
				board.check_word(result);
			if (start && !busy)
				board.note_command(cmd);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				quiet = 0;
			else
				quiet = quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("no progress for %0d cycles", QUIET_LIMIT);
				$display("FAIL bond_angle_enumerator");
				$finish;
			end
		end
	end

	// called at a rising edge; returns at the edge where the word was taken
	task automatic send_word(input logic op, input atom_t r, input atom_t s);
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < idle_pct);
		end
		start <= 1'b1;
		cmd.op <= op;
		cmd.first_atom <= r;
		cmd.second_atom <= s;
		@(posedge clk);
		while (busy) @(posedge clk);
		sent++;
	endtask

	task automatic wait_idle();
		start <= 1'b0;
		@(negedge clk);
		while (board.pending_size() > 0) @(negedge clk);
		@(posedge clk);
	endtask

	// bonds drawn from a narrow window of atoms so that angles are common
	task automatic pool_run(input int n, input bit wipe);
		atom_t base;
		int span;
		base = ($urandom_range(2) == 0) ? 8'd250 : atom_t'($urandom);
		span = $urandom_range(1, 15);
		if (wipe)
			send_word(OP_CLEAR, atom_t'($urandom), atom_t'($urandom));
		for (int k = 0; k < n; k++)
			send_word(OP_ADD, base + atom_t'($urandom_range(span)),
				base + atom_t'($urandom_range(span)));
	endtask

	// every bond shares one hub atom, so the last bond that fits sees all the others
	task automatic star_run();
		atom_t hub;
		atom_t spoke;
		hub = atom_t'($urandom);
		send_word(OP_CLEAR, '0, '0);
		for (int k = 0; k <= TABLE_DEPTH; k++) begin
			spoke = hub + atom_t'(k + 1);
			if ($urandom_range(1))
				send_word(OP_ADD, hub, spoke);
			else
				send_word(OP_ADD, spoke, hub);
		end
	endtask

	task automatic random_step();
		int pick;
		pick = $urandom_range(99);
		if (pick < 55) begin
			pool_run($urandom_range(1, 30), 1'b1);
		end else if (pick < 70) begin
			pool_run($urandom_range(1, 12), 1'b0);
		end else if (pick < 90) begin
			repeat ($urandom_range(1, 8))
				send_word(($urandom_range(7) == 0) ? OP_CLEAR : OP_ADD,
					atom_t'($urandom), atom_t'($urandom));
		end else if (pick < 96) begin
			pool_run($urandom_range(TABLE_DEPTH, TABLE_DEPTH + 6), 1'b1);
		end else begin
			star_run();
		end
	endtask

	initial begin
		int phase_pct[3];
		int phase_end[3];
		phase_pct = '{0, 49, 15};
		phase_end = '{150, 290, WORD_TARGET};
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: each matching rule, degenerate bonds, extremes, clears
		send_word(OP_CLEAR, 8'd255, 8'd255);
		send_word(OP_ADD, 8'd10, 8'd20);
		send_word(OP_ADD, 8'd10, 8'd30);
		send_word(OP_ADD, 8'd40, 8'd10);
		send_word(OP_ADD, 8'd20, 8'd50);
		send_word(OP_ADD, 8'd60, 8'd30);
		send_word(OP_ADD, 8'd10, 8'd20);
		send_word(OP_ADD, 8'd20, 8'd10);
		send_word(OP_ADD, 8'd70, 8'd70);
		send_word(OP_ADD, 8'd70, 8'd80);
		send_word(OP_ADD, 8'd0, 8'd255);
		send_word(OP_ADD, 8'd255, 8'd0);
		send_word(OP_ADD, 8'd255, 8'd255);
		send_word(OP_ADD, 8'd0, 8'd0);
		send_word(OP_ADD, 8'd0, 8'd170);
		send_word(OP_CLEAR, 8'd85, 8'd170);
		send_word(OP_ADD, 8'd0, 8'd0);
		send_word(OP_ADD, 8'd0, 8'd85);
		send_word(OP_CLEAR, 8'd0, 8'd0);
		send_word(OP_ADD, 8'd5, 8'd6);
		wait_idle();

		star_run();
		for (int p = 0; p < 3; p++) begin
			idle_pct = phase_pct[p];
			while (sent < phase_end[p])
				random_step();
			wait_idle();
		end

		repeat (80) @(posedge clk);
		if (board.pending_size() > 0) begin
			$display("%0d expected words never arrived", board.pending_size());
			board.faults = board.faults + board.pending_size();
		end
		$display("sent %0d commands: %0d clears, %0d adds refused by a full table",
			board.commands, board.clears, board.drops);
		$display("checked %0d angle words and %0d status words, %0d faults",
			board.angle_words, board.status_words, board.faults);
		if (board.faults == 0)
			$display("PASS bond_angle_enumerator");
		else
			$display("FAIL bond_angle_enumerator");
		$finish;
	end

endmodule
